FILE: rtl/core/bmhq_pkg.sv
// Shared types and constants for the binary min-heap queue.
package bmhq_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_BITS_DEF = 8;
	localparam int IDENT_W      = 6;
	localparam int OUT_KEY_W    = 8;
	localparam int FILL_W       = 7;

	typedef enum logic [1:0] {
		FUNC_PUSH  = 2'd0,
		FUNC_POP   = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_UP,
		ST_POPRD,
		ST_DOWN,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [IDENT_W-1:0]   ident;
		logic [OUT_KEY_W-1:0] key;
		stat_t                status;
		logic [FILL_W-1:0]    fill;
	} result_t;

endpackage

FILE: rtl/core/bmhq_mem.sv
// Heap slot store: one write port, two registered read ports.
module bmhq_mem #(
	parameter int DEPTH = bmhq_pkg::CAPACITY_DEF,
	parameter int DW    = bmhq_pkg::KEY_BITS_DEF + bmhq_pkg::IDENT_W
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DW-1:0]            wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
	input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
	output logic [DW-1:0]            rd_a_data,
	output logic [DW-1:0]            rd_b_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_data <= mem[rd_a_addr];
		rd_b_data <= mem[rd_b_addr];
	end

endmodule

FILE: rtl/core/bmhq_ctrl.sv
// Heap sequencer: decodes requests and walks sift-up / sift-down one level per cycle.
module bmhq_ctrl #(
	parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = bmhq_pkg::KEY_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic [1:0]                               func,
	input  logic [KEY_BITS-1:0]                      key,
	input  logic [bmhq_pkg::IDENT_W-1:0]             ident,
	output logic                                     res_valid,
	input  logic                                     res_ready,
	output bmhq_pkg::result_t                        res,
	output logic                                     wr_en,
	output logic [$clog2(CAPACITY)-1:0]              wr_addr,
	output logic [KEY_BITS+bmhq_pkg::IDENT_W-1:0]    wr_data,
	output logic [$clog2(CAPACITY)-1:0]              rd_a_addr,
	output logic [$clog2(CAPACITY)-1:0]              rd_b_addr,
	input  logic [KEY_BITS+bmhq_pkg::IDENT_W-1:0]    rd_a_data,
	input  logic [KEY_BITS+bmhq_pkg::IDENT_W-1:0]    rd_b_data
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = CW + 1;
	localparam int IW = bmhq_pkg::IDENT_W;
	localparam int DW = KEY_BITS + IW;

	function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] p);
		logic [AW-1:0] m;
		m = p - AW'(1);
		return m >> 1;
	endfunction

	function automatic logic [PW-1:0] left_of(input logic [AW-1:0] p);
		return (PW'(p) << 1) + PW'(1);
	endfunction

	bmhq_pkg::state_t state_q, state_d;
	bmhq_pkg::func_t  func_q, func_d;
	bmhq_pkg::stat_t  status_q, status_d;
	logic [DW-1:0]       mv_q, mv_d;
	logic [AW-1:0]       pos_q, pos_d;
	logic [CW-1:0]       cnt_q, cnt_d;
	logic [KEY_BITS-1:0] res_key_q, res_key_d;
	logic [IW-1:0]       res_id_q, res_id_d;

	logic [KEY_BITS-1:0] mv_key, a_key, b_key, l_best_key;
	logic [PW-1:0]       left_idx, right_idx;
	logic                push_full, pop_empty, up_move;
	logic                l_ok, r_ok, take_l, take_r;

	assign mv_key     = mv_q[DW-1 -: KEY_BITS];
	assign a_key      = rd_a_data[DW-1 -: KEY_BITS];
	assign b_key      = rd_b_data[DW-1 -: KEY_BITS];
	assign push_full  = (cnt_q == CW'(CAPACITY));
	assign pop_empty  = (cnt_q == '0);
	assign up_move    = (pos_q != '0) && (a_key > mv_key);
	assign left_idx   = left_of(pos_q);
	assign right_idx  = left_idx + PW'(1);
	assign l_ok       = (left_idx < PW'(cnt_q));
	assign r_ok       = (right_idx < PW'(cnt_q));
	assign take_l     = l_ok && (a_key < mv_key);
	assign l_best_key = take_l ? a_key : mv_key;
	assign take_r     = r_ok && (b_key < l_best_key);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bmhq_pkg::ST_IDLE: begin
				if (in_valid) state_d = bmhq_pkg::ST_START;
			end
			bmhq_pkg::ST_START: begin
				if (func_q == bmhq_pkg::FUNC_PUSH && !push_full) begin
					state_d = bmhq_pkg::ST_UP;
				end else if (func_q == bmhq_pkg::FUNC_POP && !pop_empty) begin
					state_d = bmhq_pkg::ST_POPRD;
				end else begin
					state_d = bmhq_pkg::ST_RESP;
				end
			end
			bmhq_pkg::ST_UP: begin
				if (!up_move) state_d = bmhq_pkg::ST_RESP;
			end
			bmhq_pkg::ST_POPRD: begin
				state_d = pop_empty ? bmhq_pkg::ST_RESP : bmhq_pkg::ST_DOWN;
			end
			bmhq_pkg::ST_DOWN: begin
				if (!(take_l || take_r)) state_d = bmhq_pkg::ST_RESP;
			end
			bmhq_pkg::ST_RESP: begin
				if (res_ready) state_d = bmhq_pkg::ST_IDLE;
			end
			default: state_d = bmhq_pkg::ST_IDLE;
		endcase
	end

	// datapath and memory accesses
	always_comb begin
		func_d    = func_q;
		mv_d      = mv_q;
		pos_d     = pos_q;
		cnt_d     = cnt_q;
		status_d  = status_q;
		res_key_d = res_key_q;
		res_id_d  = res_id_q;
		wr_en     = 1'b0;
		wr_addr   = pos_q;
		wr_data   = mv_q;
		rd_a_addr = '0;
		rd_b_addr = '0;
		case (state_q)
			bmhq_pkg::ST_IDLE: begin
				if (in_valid) begin
					func_d = bmhq_pkg::func_t'(func);
					mv_d   = {key, ident};
				end
			end
			bmhq_pkg::ST_START: begin
				res_key_d = '0;
				res_id_d  = '0;
				status_d  = bmhq_pkg::STAT_DONE;
				case (func_q)
					bmhq_pkg::FUNC_PUSH: begin
						if (push_full) begin
							status_d = bmhq_pkg::STAT_FULL;
						end else begin
							cnt_d     = cnt_q + CW'(1);
							pos_d     = cnt_q[AW-1:0];
							rd_a_addr = parent_of(cnt_q[AW-1:0]);
						end
					end
					bmhq_pkg::FUNC_POP: begin
						if (pop_empty) begin
							status_d = bmhq_pkg::STAT_EMPTY;
						end else begin
							cnt_d     = cnt_q - CW'(1);
							rd_b_addr = AW'(cnt_q - CW'(1));
						end
					end
					bmhq_pkg::FUNC_CLEAR: cnt_d = '0;
					default: ;
				endcase
			end
			bmhq_pkg::ST_UP: begin
				// drop the parent into the hole, or settle the new entry here
				wr_en = 1'b1;
				if (up_move) begin
					wr_data   = rd_a_data;
					pos_d     = parent_of(pos_q);
					rd_a_addr = parent_of(parent_of(pos_q));
				end
			end
			bmhq_pkg::ST_POPRD: begin
				res_key_d = rd_a_data[DW-1 -: KEY_BITS];
				res_id_d  = rd_a_data[IW-1:0];
				mv_d      = rd_b_data;
				pos_d     = '0;
				rd_a_addr = AW'(1);
				rd_b_addr = AW'(2);
			end
			bmhq_pkg::ST_DOWN: begin
				wr_en = 1'b1;
				if (take_r) begin
					wr_data = rd_b_data;
					pos_d   = right_idx[AW-1:0];
				end else if (take_l) begin
					wr_data = rd_a_data;
					pos_d   = left_idx[AW-1:0];
				end
				rd_a_addr = AW'(left_of(pos_d));
				rd_b_addr = AW'(left_of(pos_d) + PW'(1));
			end
			bmhq_pkg::ST_RESP: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmhq_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		func_q    <= func_d;
		mv_q      <= mv_d;
		pos_q     <= pos_d;
		status_q  <= status_d;
		res_key_q <= res_key_d;
		res_id_q  <= res_id_d;
	end

	assign in_stall   = (state_q != bmhq_pkg::ST_IDLE);
	assign res_valid  = (state_q == bmhq_pkg::ST_RESP);
	assign res.ident  = res_id_q;
	assign res.key    = bmhq_pkg::OUT_KEY_W'(res_key_q);
	assign res.status = status_q;
	assign res.fill   = bmhq_pkg::FILL_W'(cnt_q);

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_cnt_only_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != bmhq_pkg::ST_START) |=> $stable(cnt_q))
		else $error("entry count moved outside request decode");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bmhq_pkg::ST_START && func_q == bmhq_pkg::FUNC_POP && !pop_empty)
		|=> (state_q == bmhq_pkg::ST_POPRD && cnt_q == $past(cnt_q) - CW'(1)))
		else $error("pop did not take one entry");

	a_down_deeper: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bmhq_pkg::ST_DOWN) ##1 (state_q == bmhq_pkg::ST_DOWN)
		|-> (pos_q > $past(pos_q)))
		else $error("sift-down did not descend");

	a_up_shallower: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bmhq_pkg::ST_UP) ##1 (state_q == bmhq_pkg::ST_UP)
		|-> (pos_q < $past(pos_q)))
		else $error("sift-up did not climb");

endmodule

FILE: rtl/core/binary_min_heap_queue.sv
// Top level of the binary min-heap queue: sequencer, slot store and result register.
//
// Requests arrive on the input channel (in_valid / in_stall) with func, key and
// ident; func selects push, pop minimum or clear, code 3 does nothing. Every
// request yields exactly one result beat on the output channel (out_valid /
// out_stall): the popped ident and key (zero unless a pop succeeded), a status
// (done, pop refused on empty, push refused on full) and the fill level after
// the request.
// One request is worked at a time. A clear, a no-op or a refused request goes
// from decode straight to the result; a push walks the sift-up, and a pop reads
// the root and the last slot, then walks the sift-down before its result;
// a pop that leaves the heap empty skips the sift-down.
// The sift walk reads and writes the slot memory one level per cycle through
// its registered read ports.
// The result sits in an output register, so the next request is accepted while
// a result is still stalled; a further result waits in the sequencer until the
// register frees. At reset the fill level goes to zero and both channels idle;
// the slot memory is not cleared, as only slots below the fill level are used.
module binary_min_heap_queue #(
	parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = bmhq_pkg::KEY_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        func,
	input  logic [KEY_BITS-1:0]               key,
	input  logic [bmhq_pkg::IDENT_W-1:0]      ident,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [bmhq_pkg::IDENT_W-1:0]      out_ident,
	output logic [bmhq_pkg::OUT_KEY_W-1:0]    out_key,
	output logic [1:0]                        status,
	output logic [bmhq_pkg::FILL_W-1:0]       fill
);

	localparam int AW = $clog2(CAPACITY);
	localparam int DW = KEY_BITS + bmhq_pkg::IDENT_W;

	logic              res_valid, res_ready;
	bmhq_pkg::result_t res;
	logic              wr_en;
	logic [AW-1:0]     wr_addr, rd_a_addr, rd_b_addr;
	logic [DW-1:0]     wr_data, rd_a_data, rd_b_data;

	logic              out_valid_q;
	bmhq_pkg::result_t out_q;

	bmhq_ctrl #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.key       (key),
		.ident     (ident),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_a_addr (rd_a_addr),
		.rd_b_addr (rd_b_addr),
		.rd_a_data (rd_a_data),
		.rd_b_data (rd_b_data)
	);

	bmhq_mem #(
		.DEPTH (CAPACITY),
		.DW    (DW)
	) u_mem (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_a_addr (rd_a_addr),
		.rd_b_addr (rd_b_addr),
		.rd_a_data (rd_a_data),
		.rd_b_data (rd_b_data)
	);

	// take a new result when the register is empty or its beat leaves this cycle
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	// hold the payload while stalled
	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_ident = out_q.ident;
	assign out_key   = out_q.key;
	assign status    = out_q.status;
	assign fill      = out_q.fill;

endmodule
